/* rtl/core/lgep_pkg.sv */
`timescale 1ns / 1ps

package lgep_pkg;

  // Input event beat.
  typedef struct packed {
    logic [4:0]         event_type;
    logic [9:0]         event_code;
    logic signed [31:0] event_value;
  } evt_t;

  // Result beat.
  typedef struct packed {
    logic        result_kind;
    logic [3:0]  button_index;
    logic        button_pressed;
    logic [12:0] pointer_x;
    logic [12:0] pointer_y;
  } res_t;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic signed [31:0] x_axis_min;
    logic signed [31:0] x_axis_max;
    logic signed [31:0] y_axis_min;
    logic signed [31:0] y_axis_max;
    logic [12:0]        window_width;
    logic [12:0]        window_height;
    logic               absolute_mode;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_ABS_X  = 3'd0,
    OP_ABS_Y  = 3'd1,
    OP_REL_X  = 3'd2,
    OP_REL_Y  = 3'd3,
    OP_BUTTON = 3'd4,
    OP_SYNC   = 3'd5
  } op_t;

  // Classified command passed from the front to the back through the queue.
  typedef struct packed {
    op_t                op;
    logic [3:0]         button;
    logic signed [31:0] value;
  } cmd_t;

  // Event classes.
  localparam logic [4:0] EV_SYNC = 5'd0;
  localparam logic [4:0] EV_KEY  = 5'd1;
  localparam logic [4:0] EV_REL  = 5'd2;
  localparam logic [4:0] EV_ABS  = 5'd3;

  localparam logic [9:0] CODE_X          = 10'd0;
  localparam logic [9:0] CODE_Y          = 10'd1;
  localparam logic [9:0] CODE_SYNC       = 10'd0;
  localparam logic [9:0] CODE_KEY_LT     = 10'd272;
  localparam logic [9:0] CODE_KEY_RT     = 10'd273;
  localparam logic [9:0] CODE_KEY_MID    = 10'd274;
  localparam logic [9:0] CODE_BTN_FIRST  = 10'd257;
  localparam logic [9:0] CODE_BTN_LAST   = 10'd264;

  localparam logic [3:0] IDX_LT         = 4'd0;
  localparam logic [3:0] IDX_RT         = 4'd1;
  localparam logic [3:0] IDX_MID        = 4'd2;
  localparam logic [3:0] BTN_EXTRA_BASE = 4'd3;

  localparam logic        KIND_BUTTON  = 1'b0;
  localparam logic        KIND_POINTER = 1'b1;

  localparam logic [16:0] FRAC_ONE  = 17'd65536;
  localparam logic [16:0] FRAC_HALF = 17'd32768;
  localparam logic [12:0] DEFAULT_W = 13'd1920;
  localparam logic [12:0] DEFAULT_H = 13'd1080;

  localparam int FRAC_BITS = 16;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_X_MIN  = 3'd0;
  localparam logic [2:0] REG_X_MAX  = 3'd1;
  localparam logic [2:0] REG_Y_MIN  = 3'd2;
  localparam logic [2:0] REG_Y_MAX  = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;
  localparam logic [2:0] REG_MODE   = 3'd6;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

endpackage

/* rtl/core/lgep_front.sv */
`timescale 1ns / 1ps

module lgep_front (
  input  logic              evt_valid,
  output logic              evt_stall,
  input  lgep_pkg::evt_t    evt,
  input  logic              queue_full,
  output logic              push,
  output lgep_pkg::cmd_t    cmd
);

  logic       keep;
  logic [9:0] extra;

  assign extra = evt.event_code - lgep_pkg::CODE_BTN_FIRST;

  always_comb begin
    keep       = 1'b0;
    cmd.op     = lgep_pkg::OP_SYNC;
    cmd.button = '0;
    cmd.value  = evt.event_value;
    case (evt.event_type)
      lgep_pkg::EV_ABS: begin
        if (evt.event_code == lgep_pkg::CODE_X) begin
          keep   = 1'b1;
          cmd.op = lgep_pkg::OP_ABS_X;
        end else if (evt.event_code == lgep_pkg::CODE_Y) begin
          keep   = 1'b1;
          cmd.op = lgep_pkg::OP_ABS_Y;
        end
      end
      lgep_pkg::EV_REL: begin
        if (evt.event_code == lgep_pkg::CODE_X) begin
          keep   = 1'b1;
          cmd.op = lgep_pkg::OP_REL_X;
        end else if (evt.event_code == lgep_pkg::CODE_Y) begin
          keep   = 1'b1;
          cmd.op = lgep_pkg::OP_REL_Y;
        end
      end
      lgep_pkg::EV_KEY: begin
        cmd.op = lgep_pkg::OP_BUTTON;
        // Only a plain press or release of a mapped button is passed on.
        if (evt.event_value == 32'sd0 || evt.event_value == 32'sd1) begin
          if (evt.event_code == lgep_pkg::CODE_KEY_LT) begin
            keep       = 1'b1;
            cmd.button = lgep_pkg::IDX_LT;
          end else if (evt.event_code == lgep_pkg::CODE_KEY_RT) begin
            keep       = 1'b1;
            cmd.button = lgep_pkg::IDX_RT;
          end else if (evt.event_code == lgep_pkg::CODE_KEY_MID) begin
            keep       = 1'b1;
            cmd.button = lgep_pkg::IDX_MID;
          end else if (evt.event_code >= lgep_pkg::CODE_BTN_FIRST &&
                       evt.event_code <= lgep_pkg::CODE_BTN_LAST) begin
            keep       = 1'b1;
            cmd.button = lgep_pkg::BTN_EXTRA_BASE + extra[3:0];
          end
        end
      end
      lgep_pkg::EV_SYNC: begin
        if (evt.event_code == lgep_pkg::CODE_SYNC) begin
          keep   = 1'b1;
          cmd.op = lgep_pkg::OP_SYNC;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign evt_stall = queue_full;
  assign push      = evt_valid && !queue_full && keep;

endmodule

/* rtl/core/lgep_queue.sv */
`timescale 1ns / 1ps

module lgep_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lgep_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output lgep_pkg::cmd_t head
);

  lgep_pkg::cmd_t              entries [lgep_pkg::QUEUE_DEPTH];
  logic [lgep_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [lgep_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [lgep_pkg::QUEUE_AW:0]   count;

  assign full  = (count == (lgep_pkg::QUEUE_AW+1)'(lgep_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/lgep_back.sv */
`timescale 1ns / 1ps

module lgep_back (
  input  logic           clk,
  input  logic           rst,
  input  lgep_pkg::cfg_t cfg,
  input  logic           empty,
  input  lgep_pkg::cmd_t head,
  output logic           pop,
  output logic           res_valid,
  input  logic           res_stall,
  output lgep_pkg::res_t res
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_MULX  = 7'b0010000,
    S_MULY  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t             state;
  lgep_pkg::cmd_t     cmd;
  lgep_pkg::res_t     pend_res;
  logic [16:0]        x_fraction;
  logic [16:0]        y_fraction;
  logic signed [31:0] x_position;
  logic signed [31:0] y_position;
  logic               update_pending;
  logic               clamp_now;
  logic signed [32:0] rng;
  logic signed [32:0] num;
  logic [32:0]        rem;
  logic [15:0]        quo;
  logic [3:0]         step;

  logic [12:0]        w;
  logic [12:0]        h;
  logic signed [31:0] lo;
  logic signed [31:0] hi;
  logic signed [31:0] pos_sel;
  logic signed [32:0] sum;
  logic signed [31:0] sat;
  logic [32:0]        trial;
  logic               fit;
  logic [29:0]        prod_x;
  logic [29:0]        prod_y;
  logic [31:0]        x_clamped;
  logic [31:0]        y_clamped;
  logic [16:0]        frac_done;
  logic               load_res;

  assign w = (cfg.window_width == '0) ? lgep_pkg::DEFAULT_W : cfg.window_width;
  assign h = (cfg.window_height == '0) ? lgep_pkg::DEFAULT_H : cfg.window_height;

  assign lo = (cmd.op == lgep_pkg::OP_ABS_Y) ? cfg.y_axis_min : cfg.x_axis_min;
  assign hi = (cmd.op == lgep_pkg::OP_ABS_Y) ? cfg.y_axis_max : cfg.x_axis_max;

  // Saturating relative move.
  assign pos_sel = (cmd.op == lgep_pkg::OP_REL_Y) ? y_position : x_position;
  assign sum     = {pos_sel[31], pos_sel} + {cmd.value[31], cmd.value};
  always_comb begin
    if (sum[32] != sum[31]) begin
      sat = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat = sum[31:0];
    end
  end

  // One restoring step of the fraction divide; the remainder stays below the range.
  assign trial     = {rem[31:0], 1'b0};
  assign fit       = (trial >= {1'b0, rng[31:0]});
  assign frac_done = {1'b0, quo[14:0], fit};

  assign prod_x = x_fraction * w;
  assign prod_y = y_fraction * h;

  always_comb begin
    if (x_position[31]) begin
      x_clamped = '0;
    end else if (x_position > $signed({19'b0, w})) begin
      x_clamped = {19'b0, w};
    end else begin
      x_clamped = x_position;
    end
    if (y_position[31]) begin
      y_clamped = '0;
    end else if (y_position > $signed({19'b0, h})) begin
      y_clamped = {19'b0, h};
    end else begin
      y_clamped = y_position;
    end
  end

  assign pop      = (state == S_IDLE) && !empty;
  assign load_res = (state == S_EMIT) && !clamp_now && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      res_valid      <= 1'b0;
      update_pending <= 1'b0;
      clamp_now      <= 1'b0;
      x_fraction     <= lgep_pkg::FRAC_HALF;
      y_fraction     <= lgep_pkg::FRAC_HALF;
      x_position     <= $signed({20'b0, lgep_pkg::DEFAULT_W[12:1]});
      y_position     <= $signed({20'b0, lgep_pkg::DEFAULT_H[12:1]});
    end else begin
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!empty) begin
            cmd   <= head;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cmd.op)
            lgep_pkg::OP_ABS_X, lgep_pkg::OP_ABS_Y: begin
              rng            <= {hi[31], hi} - {lo[31], lo};
              num            <= {cmd.value[31], cmd.value} - {lo[31], lo};
              update_pending <= 1'b1;
              state          <= S_CHECK;
            end
            lgep_pkg::OP_REL_X: begin
              x_position     <= sat;
              update_pending <= 1'b1;
              state          <= S_IDLE;
            end
            lgep_pkg::OP_REL_Y: begin
              y_position     <= sat;
              update_pending <= 1'b1;
              state          <= S_IDLE;
            end
            lgep_pkg::OP_BUTTON: begin
              pend_res.result_kind    <= lgep_pkg::KIND_BUTTON;
              pend_res.button_index   <= cmd.button;
              pend_res.button_pressed <= cmd.value[0];
              pend_res.pointer_x      <= '0;
              pend_res.pointer_y      <= '0;
              clamp_now               <= 1'b0;
              state                   <= S_EMIT;
            end
            default: begin
              // Sync report.
              if (!update_pending) begin
                state <= S_IDLE;
              end else if (cfg.absolute_mode) begin
                state <= S_MULX;
              end else begin
                clamp_now <= 1'b1;
                state     <= S_EMIT;
              end
            end
          endcase
        end
        S_CHECK: begin
          if (rng[32] || rng == '0) begin
            if (cmd.op == lgep_pkg::OP_ABS_Y) y_fraction <= lgep_pkg::FRAC_HALF;
            else x_fraction <= lgep_pkg::FRAC_HALF;
            state <= S_IDLE;
          end else if (num[32] || num == '0) begin
            if (cmd.op == lgep_pkg::OP_ABS_Y) y_fraction <= '0;
            else x_fraction <= '0;
            state <= S_IDLE;
          end else if (num >= rng) begin
            if (cmd.op == lgep_pkg::OP_ABS_Y) y_fraction <= lgep_pkg::FRAC_ONE;
            else x_fraction <= lgep_pkg::FRAC_ONE;
            state <= S_IDLE;
          end else begin
            rem   <= num;
            quo   <= '0;
            step  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= fit ? (trial - {1'b0, rng[31:0]}) : trial;
          quo  <= frac_done[15:0];
          step <= step + 1'b1;
          if (step == 4'(lgep_pkg::FRAC_BITS - 1)) begin
            if (cmd.op == lgep_pkg::OP_ABS_Y) y_fraction <= frac_done;
            else x_fraction <= frac_done;
            state <= S_IDLE;
          end
        end
        S_MULX: begin
          x_position <= $signed({18'b0, prod_x[29:16]});
          state      <= S_MULY;
        end
        S_MULY: begin
          y_position <= $signed({18'b0, prod_y[29:16]});
          clamp_now  <= 1'b1;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          // A sync result clamps here, so it sees the finished positions.
          if (clamp_now) begin
            x_position              <= x_clamped;
            y_position              <= y_clamped;
            update_pending          <= 1'b0;
            clamp_now               <= 1'b0;
            pend_res.result_kind    <= lgep_pkg::KIND_POINTER;
            pend_res.button_index   <= '0;
            pend_res.button_pressed <= 1'b0;
            pend_res.pointer_x      <= x_clamped[12:0];
            pend_res.pointer_y      <= y_clamped[12:0];
          end else if (load_res) begin
            res   <= pend_res;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/light_gun_event_to_pointer.sv */
`timescale 1ns / 1ps

// Light gun event to pointer translator.
// Input events (type, code, value) arrive as beats on the evt channel; button
// and pointer results leave as beats on the res channel. Both channels use
// valid and stall, and a beat moves when valid is high and stall is low.
// A front stage classifies each event and drops the ones with no effect; kept
// events wait in a four-entry queue, so evt_stall rises only when it is full.
// The back stage runs one queued event at a time. A relative move updates the
// position and ends; a button event goes straight to the emit state, and a sync
// clamps the positions there before it emits in relative mode, or first runs two
// multiplies by the window size in absolute mode; res_valid is registered. An
// absolute axis event holds the back stage through a range check and the
// 16-step serial divide by the axis range, so no new event is taken until the
// divide ends. A stall on res holds the result register and the back stage; the
// queue keeps taking events until it fills.
// Reset (rst, synchronous) empties the queue, clears the pending flag, sets
// both fractions to one half and the position to the middle of a 1920x1080
// window, and loads the register defaults. Registers are written over the
// APB-style port by the user only while the block is idle; it is not enforced.

module light_gun_event_to_pointer (
  input  logic           clk,
  input  logic           rst,
  input  logic           evt_valid,
  output logic           evt_stall,
  input  lgep_pkg::evt_t evt,
  output logic           res_valid,
  input  logic           res_stall,
  output lgep_pkg::res_t res,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  lgep_pkg::cfg_t cfg;
  lgep_pkg::cmd_t push_cmd;
  lgep_pkg::cmd_t head;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  logic           wr_en;
  logic [2:0]     reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_axis_min    <= 32'sd0;
      cfg.x_axis_max    <= 32'sd65535;
      cfg.y_axis_min    <= 32'sd0;
      cfg.y_axis_max    <= 32'sd65535;
      cfg.window_width  <= lgep_pkg::DEFAULT_W;
      cfg.window_height <= lgep_pkg::DEFAULT_H;
      cfg.absolute_mode <= 1'b0;
    end else if (wr_en) begin
      case (reg_index)
        lgep_pkg::REG_X_MIN:  cfg.x_axis_min    <= pwdata;
        lgep_pkg::REG_X_MAX:  cfg.x_axis_max    <= pwdata;
        lgep_pkg::REG_Y_MIN:  cfg.y_axis_min    <= pwdata;
        lgep_pkg::REG_Y_MAX:  cfg.y_axis_max    <= pwdata;
        lgep_pkg::REG_WIDTH:  cfg.window_width  <= pwdata[12:0];
        lgep_pkg::REG_HEIGHT: cfg.window_height <= pwdata[12:0];
        lgep_pkg::REG_MODE:   cfg.absolute_mode <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      lgep_pkg::REG_X_MIN:  prdata = cfg.x_axis_min;
      lgep_pkg::REG_X_MAX:  prdata = cfg.x_axis_max;
      lgep_pkg::REG_Y_MIN:  prdata = cfg.y_axis_min;
      lgep_pkg::REG_Y_MAX:  prdata = cfg.y_axis_max;
      lgep_pkg::REG_WIDTH:  prdata = {19'b0, cfg.window_width};
      lgep_pkg::REG_HEIGHT: prdata = {19'b0, cfg.window_height};
      lgep_pkg::REG_MODE:   prdata = {31'b0, cfg.absolute_mode};
      default:              prdata = '0;
    endcase
  end

  lgep_front u_front (
    .evt_valid  (evt_valid),
    .evt_stall  (evt_stall),
    .evt        (evt),
    .queue_full (full),
    .push       (push),
    .cmd        (push_cmd)
  );

  lgep_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  lgep_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
